@@ src/lkpt_pkg.sv @@
// Shared constants, transaction kinds and controller/datapath interface types.
`timescale 1ns / 1ps

package lkpt_pkg;

    // Default table depth
    localparam int unsigned ENTRIES_DEF = 16;

    // Field widths fixed by the transaction format
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned TOK_W     = 16;
    localparam int unsigned PAY_W     = 32;
    localparam int unsigned STAMP_W   = 64;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned OCC_OUT_W = 5;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned S_DATA_W  = 112;
    localparam int unsigned M_DATA_W  = 120;
    localparam int unsigned M_USER_W  = 2;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic commit;
        logic emit;
    } lkpt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_free;
    } lkpt_sts_t;

endpackage

@@ src/lkpt_ctrl.sv @@
// Sequencing state machine: accept, scan the table, commit, emit the result.
`timescale 1ns / 1ps

module lkpt_ctrl
    import lkpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lkpt_sts_t sts,
    output lkpt_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.scan_init = 1'b1;
                state_next    = sts.needs_scan ? ST_SCAN : ST_COMMIT;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/lkpt_dp.sv @@
// Table storage, serial key/age scan, counters and the result register.
`timescale 1ns / 1ps

module lkpt_dp
    import lkpt_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkpt_cmd_t           cmd,
    output lkpt_sts_t           sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OCCW = $clog2(ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    // Table memories
    logic [KEY_W-1:0]   key_mem   [0:ENTRIES-1];
    logic [TOK_W-1:0]   tok_mem   [0:ENTRIES-1];
    logic [PAY_W-1:0]   pay_mem   [0:ENTRIES-1];
    logic [STAMP_W-1:0] stamp_mem [0:ENTRIES-1];
    logic [ENTRIES-1:0] valid_reg;

    // Latched transaction
    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  key_in_reg;
    logic [TOK_W-1:0]  tok_in_reg;
    logic [PAY_W-1:0]  pay_in_reg;

    // Scan state
    logic [IDXW-1:0]    scan_addr_reg;
    logic [IDXW-1:0]    eval_idx_reg;
    logic               eval_vld_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;
    logic               found_reg;
    logic [IDXW-1:0]    match_idx_reg;
    logic               free_found_reg;
    logic [IDXW-1:0]    free_idx_reg;
    logic               min_seen_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [IDXW-1:0]    min_idx_reg;

    // Counters and read-back
    logic [STAMP_W-1:0] clock_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   misses_reg;
    logic [OCCW-1:0]    occ_reg;
    logic [TOK_W-1:0]   rd_tok_reg;
    logic [PAY_W-1:0]   rd_pay_reg;

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    logic            is_lookup;
    logic            is_store;
    logic            eval_slot_vld;
    logic [IDXW-1:0] target_idx;
    logic            do_write;
    logic            do_insert;
    logic            do_evict;
    logic            do_stamp;
    logic            hit_flag;
    logic [TOK_W-1:0] tok_out;
    logic [PAY_W-1:0] pay_out;

    function automatic logic do_evict_hold(input logic store, input logic found,
                                           input logic free_found);
        do_evict_hold = store && !found && !free_found;
    endfunction

    assign is_lookup     = (kind_reg == KIND_LOOKUP);
    assign is_store      = (kind_reg == KIND_STORE);
    assign eval_slot_vld = valid_reg[eval_idx_reg];
    assign target_idx    = found_reg ? match_idx_reg :
                           (free_found_reg ? free_idx_reg : min_idx_reg);
    assign do_write      = cmd.commit && is_store;
    assign do_insert     = do_write && !found_reg;
    assign do_evict      = do_insert && !free_found_reg;
    assign do_stamp      = do_write || (cmd.commit && is_lookup && found_reg);
    assign hit_flag      = (is_lookup || is_store) && found_reg;
    assign tok_out       = (is_lookup && found_reg) ? rd_tok_reg : '0;
    assign pay_out       = (is_lookup && found_reg) ? rd_pay_reg : '0;

    assign sts.needs_scan = is_lookup || is_store;
    assign sts.scan_last  = (scan_addr_reg == LAST_IDX);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Latch the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_tuser;
            key_in_reg <= s_tdata[KEY_W-1:0];
            tok_in_reg <= s_tdata[KEY_W +: TOK_W];
            pay_in_reg <= s_tdata[KEY_W+TOK_W +: PAY_W];
        end
    end

    // Key and stamp memories: read during the scan, written on commit
    always_ff @(posedge aclk) begin
        key_rd_reg   <= key_mem[scan_addr_reg];
        stamp_rd_reg <= stamp_mem[scan_addr_reg];
        if (do_insert) begin
            key_mem[target_idx] <= key_in_reg;
        end
        if (do_stamp) begin
            stamp_mem[target_idx] <= clock_reg;
        end
    end

    // Count and handle memories: read the hit slot, write on store
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rd_tok_reg <= tok_mem[target_idx];
            rd_pay_reg <= pay_mem[target_idx];
        end
        if (do_write) begin
            tok_mem[target_idx] <= tok_in_reg;
            pay_mem[target_idx] <= pay_in_reg;
        end
    end

    // Scan address and evaluation of the previous read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_vld_reg   <= 1'b0;
            scan_addr_reg  <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            min_seen_reg   <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.scan_step;
            eval_idx_reg <= scan_addr_reg;
            if (cmd.scan_init) begin
                scan_addr_reg  <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                min_seen_reg   <= 1'b0;
            end else begin
                if (cmd.scan_step && !sts.scan_last) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (eval_vld_reg) begin
                    // First matching key wins
                    if (eval_slot_vld && key_rd_reg == key_in_reg && !found_reg) begin
                        found_reg     <= 1'b1;
                        match_idx_reg <= eval_idx_reg;
                    end
                    // Lowest free slot
                    if (!eval_slot_vld && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= eval_idx_reg;
                    end
                    // Oldest stamp, lowest slot on a tie
                    if (eval_slot_vld && (!min_seen_reg || stamp_rd_reg < min_stamp_reg)) begin
                        min_seen_reg  <= 1'b1;
                        min_stamp_reg <= stamp_rd_reg;
                        min_idx_reg   <= eval_idx_reg;
                    end
                end
            end
        end
    end

    // Valid bits, occupancy, access clock and hit/miss counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            occ_reg    <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end else if (cmd.commit && kind_reg == KIND_CLEAR) begin
            valid_reg  <= '0;
            occ_reg    <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end else begin
            if (do_insert) begin
                valid_reg[target_idx] <= 1'b1;
                if (!do_evict) begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
            if (do_stamp && clock_reg != '1) begin
                clock_reg <= clock_reg + 1'b1;
            end
            if (cmd.commit && is_lookup) begin
                if (found_reg) begin
                    if (hits_reg != '1) begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end else if (misses_reg != '1) begin
                    misses_reg <= misses_reg + 1'b1;
                end
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {3'b000, OCC_OUT_W'(occ_reg), misses_reg, hits_reg,
                           pay_out, tok_out};
            m_user_reg <= {do_evict_hold(is_store, found_reg, free_found_reg), hit_flag};
        end
    end

endmodule

@@ src/lru_keyed_prefix_table.sv @@
// Top level of the LRU keyed prefix table: controller, datapath and checks.
//
//  Channel | Ports                   | Contents (lowest bit first)
//  --------+-------------------------+-----------------------------------------------
//  input   | s_tvalid/s_tready       | tuser: kind[1:0]; tdata: key[63:0],
//          |                         |   token_count[79:64], payload[111:80]
//  result  | m_tvalid/m_tready       | tuser: hit[0], evicted[1]; tdata:
//          |                         |   token_count_out, payload_out, hit_count,
//          |                         |   miss_count, occupancy[116:112]
//
// A lookup or store raises m_tvalid after acceptance by way of start, one
// key/stamp memory read per slot, drain, commit and emit; a clear or an unused
// kind skips the scan and drain. s_tready returns together with m_tvalid.
// Reset (aresetn low, synchronous) empties the table and zeroes the counters.
// A new transaction is accepted while the previous result waits; completion
// stalls only while the result register is full and m_tready is low.
`timescale 1ns / 1ps

module lru_keyed_prefix_table
    import lkpt_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key, token_count, payload
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // token_count_out, payload_out, hit_count,
                                           // miss_count, occupancy, zero pad
    output logic [M_USER_W-1:0] m_tuser    // hit, evicted
);

    lkpt_cmd_t cmd;
    lkpt_sts_t sts;

    lkpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lkpt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One transaction in flight: no second acceptance right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transaction accepted while previous one in progress");

    // A result is loaded only into a free result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    // Load, commit and emit never coincide
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.commit, cmd.emit}))
        else $error("conflicting sequencer commands");

endmodule

@@ dv/lkpt_checker.sv @@
// Checker for the LRU keyed prefix table: predicts each result and compares it.
`timescale 1ns / 1ps

module lkpt_checker
    import lkpt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key, token_count, payload
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // token_count_out, payload_out, hit_count,
                                           // miss_count, occupancy, zero pad
    input  logic [M_USER_W-1:0] m_tuser,   // hit, evicted
    output int unsigned         mismatches,
    output int unsigned         outstanding
);

    typedef struct {
        logic                 hit;
        logic [TOK_W-1:0]     tokens;
        logic [PAY_W-1:0]     payload;
        logic                 evicted;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [OCC_OUT_W-1:0] occupancy;
    } table_reply_t;

    // Shadow copy of the table
    logic                line_valid   [ENTRIES_DEF];
    logic [KEY_W-1:0]    line_key     [ENTRIES_DEF];
    logic [TOK_W-1:0]    line_tokens  [ENTRIES_DEF];
    logic [PAY_W-1:0]    line_payload [ENTRIES_DEF];
    logic [STAMP_W-1:0]  line_age     [ENTRIES_DEF];
    logic [STAMP_W-1:0]  age_clock;
    logic [CNT_W-1:0]    hit_tally;
    logic [CNT_W-1:0]    miss_tally;

    table_reply_t replies_due [$];

    // Hand out the current access time and advance it, holding at all ones
    function automatic logic [STAMP_W-1:0] take_age();
        logic [STAMP_W-1:0] now;
        now = age_clock;
        if (age_clock != '1)
            age_clock = age_clock + 1'b1;
        return now;
    endfunction

    function automatic int find_line(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES_DEF; i++)
            if (line_valid[i] && line_key[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and work out its result
    function automatic table_reply_t apply_request(input logic [KIND_W-1:0] kind,
                                                   input logic [KEY_W-1:0]  key,
                                                   input logic [TOK_W-1:0]  tokens,
                                                   input logic [PAY_W-1:0]  payload);
        table_reply_t r;
        int           slot;
        int           filled;
        r = '{hit: 1'b0, tokens: '0, payload: '0, evicted: 1'b0,
              hits: '0, misses: '0, occupancy: '0};
        case (kind)
            KIND_LOOKUP: begin
                slot = find_line(key);
                if (slot >= 0) begin
                    r.hit          = 1'b1;
                    r.tokens       = line_tokens[slot];
                    r.payload      = line_payload[slot];
                    line_age[slot] = take_age();
                    if (hit_tally != '1)
                        hit_tally = hit_tally + 1'b1;
                end else if (miss_tally != '1) begin
                    miss_tally = miss_tally + 1'b1;
                end
            end
            KIND_STORE: begin
                slot = find_line(key);
                if (slot >= 0) begin
                    r.hit = 1'b1;
                end else begin
                    // lowest free slot first, else the oldest (lowest index on a tie)
                    for (int i = 0; i < ENTRIES_DEF; i++)
                        if (!line_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < ENTRIES_DEF; i++)
                            if (line_age[i] < line_age[slot])
                                slot = i;
                        r.evicted = 1'b1;
                    end
                    line_valid[slot] = 1'b1;
                    line_key[slot]   = key;
                end
                line_tokens[slot]  = tokens;
                line_payload[slot] = payload;
                line_age[slot]     = take_age();
            end
            KIND_CLEAR: begin
                for (int i = 0; i < ENTRIES_DEF; i++)
                    line_valid[i] = 1'b0;
                hit_tally  = '0;
                miss_tally = '0;
                age_clock  = '0;
            end
            default: ;  // spare kind leaves everything alone
        endcase
        filled = 0;
        for (int i = 0; i < ENTRIES_DEF; i++)
            if (line_valid[i])
                filled++;
        r.hits      = hit_tally;
        r.misses    = miss_tally;
        r.occupancy = OCC_OUT_W'(filled);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge aclk) begin : watch
        table_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES_DEF; i++)
                line_valid[i] = 1'b0;
            age_clock  = '0;
            hit_tally  = '0;
            miss_tally = '0;
            mismatches = 0;
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending, tuser %0h tdata %0h",
                                 $time, m_tuser, m_tdata);
                end else begin
                    want = replies_due.pop_front();
                    check_field("hit",             64'(want.hit),       64'(m_tuser[0]));
                    check_field("evicted",         64'(want.evicted),   64'(m_tuser[1]));
                    check_field("token_count_out", 64'(want.tokens),    64'(m_tdata[15:0]));
                    check_field("payload_out",     64'(want.payload),   64'(m_tdata[47:16]));
                    check_field("hit_count",       64'(want.hits),      64'(m_tdata[79:48]));
                    check_field("miss_count",      64'(want.misses),    64'(m_tdata[111:80]));
                    check_field("occupancy",       64'(want.occupancy), 64'(m_tdata[116:112]));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_request(s_tuser, s_tdata[63:0],
                                                    s_tdata[79:64], s_tdata[111:80]));
        end
        outstanding = replies_due.size();
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the LRU keyed prefix table: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import lkpt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int LONG_HOLD     = 300;
    localparam int STUCK_LIMIT   = 5000;
    localparam int POOL_SIZE     = 28;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // key, token_count, payload
    logic [KIND_W-1:0]   s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // token_count_out, payload_out, hit_count,
                                    // miss_count, occupancy, zero pad
    logic [M_USER_W-1:0] m_tuser;   // hit, evicted

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned stuck_cycles;
    logic        no_idle;
    logic        hold_req;
    logic        hold_done;

    lru_keyed_prefix_table #(
        .ENTRIES (ENTRIES_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lkpt_checker table_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offer one request, hold it until accepted, then maybe idle for a burst
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [TOK_W-1:0] tokens, input logic [PAY_W-1:0] payload);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {payload, tokens, key};
        do @(posedge aclk); while (!s_tready);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        m_tready <= 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic [TOK_W-1:0] tokens;
        logic [PAY_W-1:0] payload;
        logic [KIND_W-1:0] kind;
        int               pool_span;
        int               pick;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty miss, extreme fields, hits, update, spare kind
        issue(KIND_LOOKUP, '0, '0, '0);
        issue(KIND_STORE,  '0, '0, '0);
        issue(KIND_STORE,  '1, '1, '1);
        issue(KIND_LOOKUP, '0, '1, '1);
        issue(KIND_LOOKUP, '1, '0, '0);
        issue(KIND_STORE,  '0, 16'h1234, 32'h89AB_CDEF);
        issue(KIND_SPARE,  '1, '1, '1);
        issue(KIND_LOOKUP, 64'h5A5A_0000_FFFF_0001, '0, '0);
        // Fill the table, then overflow it so the oldest entry goes
        for (int i = 1; i <= 14; i++)
            issue(KIND_STORE, {32'hA5A5_0000 | 32'(i), $urandom}, 16'($urandom),
                  $urandom);
        issue(KIND_STORE,  64'hC3C3_0000_0000_0077, 16'h00FF, 32'h0000_FFFF);
        issue(KIND_LOOKUP, '1, '0, '0);
        issue(KIND_CLEAR,  '1, '1, '1);
        issue(KIND_LOOKUP, '0, '0, '0);

        // Random part: keys mostly drawn from a small pool so hits and evictions occur
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        pool_span = 15;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) begin
                case ($urandom_range(0, 3))
                    0: pool_span = 5;
                    1: pool_span = 15;
                    2: pool_span = 20;
                    default: pool_span = POOL_SIZE - 1;
                endcase
                for (int i = 2; i < POOL_SIZE; i++)
                    if ($urandom_range(0, 3) == 0)
                        key_pool[i] = {$urandom, $urandom};
            end
            no_idle = (n >= 1200 && n < 1350) || (n >= RANDOM_ITEMS - 200);
            if (n == 600)
                hold_req = 1'b1;
            // Let the block drain completely before going on
            if (n == 1000) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait (outstanding == 0);
                @(posedge aclk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 47)
                kind = KIND_LOOKUP;
            else if (pick < 97)
                kind = KIND_STORE;
            else if (pick < 99)
                kind = KIND_SPARE;
            else
                kind = KIND_CLEAR;
            if ($urandom_range(0, 19) == 0)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(0, pool_span)];
            case ($urandom_range(0, 15))
                0: tokens = '0;
                1: tokens = '1;
                default: tokens = 16'($urandom);
            endcase
            case ($urandom_range(0, 15))
                0: payload = '0;
                1: payload = '1;
                default: payload = $urandom;
            endcase
            issue(kind, key, tokens, payload);
        end

        // Wind down: wait for every result, then a little longer for strays
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (2 * (ENTRIES_DEF + 5)) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
